>>> design/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// Shared constants and types for the set-associative LRU cache tracker.
// ----------------------------------------------------------------------------
package salru_pkg;
	localparam int MAX_SET_BITS = 6;
	localparam int MAX_WAYS     = 8;
	localparam int AGE_WIDTH    = 32;
	localparam int NUM_SETS     = 1 << MAX_SET_BITS;
	localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int TAG_W        = 62;
	localparam int CNT_W        = 32;
	localparam int QDEPTH       = 2;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_STORE  = 2'd1;
	localparam logic [1:0] REQ_MODIFY = 2'd2;
	localparam logic [1:0] REQ_IFETCH = 2'd3;

	localparam logic [1:0] CFG_SET_BITS   = 2'd0;
	localparam logic [1:0] CFG_WAYS       = 2'd1;
	localparam logic [1:0] CFG_BLOCK_BITS = 2'd2;

	typedef struct packed {
		logic [MAX_SET_BITS-1:0] set_idx;
		logic [TAG_W-1:0]        tag;
		logic                    modify;
		logic [WAY_W:0]          ways;
	} cmd_t;

	typedef struct packed {
		logic              access_hit;
		logic              line_evicted;
		logic              modify_extra_hit;
		logic [CNT_W-1:0]  total_hits;
		logic [CNT_W-1:0]  total_misses;
		logic [CNT_W-1:0]  total_evictions;
	} res_t;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_UPDATE, ST_OUT} bstate_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction
endpackage

>>> design/salru_if.sv
// ----------------------------------------------------------------------------
// salru_req_if / salru_rsp_if / salru_cfg_if
// Valid/ready channels of the tracker.
// ----------------------------------------------------------------------------
interface salru_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [63:0] address;
	modport source (output valid, req_type, address, input ready);
	modport sink (input valid, req_type, address, output ready);
endinterface

interface salru_rsp_if;
	logic        valid;
	logic        ready;
	logic        access_hit;
	logic        line_evicted;
	logic        modify_extra_hit;
	logic [31:0] total_hits;
	logic [31:0] total_misses;
	logic [31:0] total_evictions;
	modport source (output valid, access_hit, line_evicted, modify_extra_hit,
		total_hits, total_misses, total_evictions, input ready);
	modport sink (input valid, access_hit, line_evicted, modify_extra_hit,
		total_hits, total_misses, total_evictions, output ready);
endinterface

interface salru_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [5:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> design/salru_front.sv
// ----------------------------------------------------------------------------
// salru_front
// Accepts accesses, drops instruction fetches, splits address into set/tag.
// ----------------------------------------------------------------------------
module salru_front import salru_pkg::*; (
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [63:0] address,
	input  logic [2:0]  set_bits_q,
	input  logic [3:0]  ways_q,
	input  logic [5:0]  blk_bits_q,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        q_full
);
	logic [2:0]  sb;
	logic [WAY_W:0] wy;
	logic [5:0]  bb;
	logic [6:0]  shamt;
	logic [63:0] sh_set, sh_tag;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full && (req_type != REQ_IFETCH);

	always_comb begin
		sb = (set_bits_q == 3'd0) ? 3'd1 :
			(set_bits_q > 3'(MAX_SET_BITS)) ? 3'(MAX_SET_BITS) : set_bits_q;
		wy = (ways_q == 4'd0) ? (WAY_W+1)'(1) :
			(ways_q > 4'(MAX_WAYS)) ? (WAY_W+1)'(MAX_WAYS) : (WAY_W+1)'(ways_q);
		bb = (blk_bits_q == 6'd0) ? 6'd1 :
			(blk_bits_q > 6'd32) ? 6'd32 : blk_bits_q;
		shamt  = 7'(bb) + 7'(sb);
		sh_set = address >> bb;
		sh_tag = address >> shamt;
		push_cmd.set_idx = MAX_SET_BITS'(sh_set & ((64'd1 << sb) - 64'd1));
		push_cmd.tag     = sh_tag[TAG_W-1:0];
		push_cmd.modify  = (req_type == REQ_MODIFY);
		push_cmd.ways    = wy;
	end
endmodule

>>> design/salru_queue.sv
// ----------------------------------------------------------------------------
// salru_queue
// Small FIFO between front and back.
// ----------------------------------------------------------------------------
module salru_queue import salru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);
	localparam int PW = $clog2(QDEPTH);
	cmd_t          mem_q [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;

	assign full  = (cnt_q == (PW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop)  rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule

>>> design/salru_back.sv
// ----------------------------------------------------------------------------
// salru_back
// Reads one set, updates ages/tags, writes the set back, holds the result.
// ----------------------------------------------------------------------------
module salru_back import salru_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  cmd_t q_head,
	output logic q_pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t res
);
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;

	logic [MAX_WAYS*TAG_W-1:0]     tag_mem  [NUM_SETS];
	logic [MAX_WAYS*AGE_WIDTH-1:0] age_mem  [NUM_SETS];
	logic [MAX_WAYS-1:0]           vld_mem  [NUM_SETS];

	bstate_t state_q, state_d;
	cmd_t    cmd_q;
	logic [MAX_WAYS*TAG_W-1:0]     tags_rd;
	logic [MAX_WAYS*AGE_WIDTH-1:0] ages_rd;
	logic [MAX_WAYS*TAG_W-1:0]     tags_wr;
	logic [MAX_WAYS*AGE_WIDTH-1:0] ages_wr;
	logic [MAX_WAYS-1:0] vld_rd, vld_wr, used, match, older;
	logic [AGE_WIDTH-1:0] aged [MAX_WAYS];
	logic hit, have_free, have_old, evict, we;
	logic [WAY_W-1:0] free_w, old_w, tgt;
	logic [AGE_WIDTH-1:0] old_age;
	logic [CNT_W-1:0] hits_q, miss_q, evc_q, hits_d, miss_d, evc_d;
	logic [MAX_SET_BITS:0] clr_q;
	logic clr_done;
	res_t res_q;

	// valid bits are cleared one set per cycle after reset
	assign clr_done  = clr_q[MAX_SET_BITS];
	assign q_pop     = (state_q == ST_IDLE) && !q_empty && clr_done;
	assign out_valid = (state_q == ST_OUT);
	assign res       = res_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (!q_empty && clr_done) state_d = ST_READ;
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_OUT;
			ST_OUT:    if (out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end
	assign we = (state_q == ST_UPDATE);

	// set read, registered
	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_head;
		tags_rd <= tag_mem[cmd_q.set_idx];
		ages_rd <= age_mem[cmd_q.set_idx];
		vld_rd  <= vld_mem[cmd_q.set_idx];
		if (we) begin
			tag_mem[cmd_q.set_idx] <= tags_wr;
			age_mem[cmd_q.set_idx] <= ages_wr;
		end
		if (!clr_done) vld_mem[clr_q[MAX_SET_BITS-1:0]] <= '0;
		else if (we)   vld_mem[cmd_q.set_idx] <= vld_wr;
	end

	always_comb begin
		have_free = 1'b0; free_w = '0;
		have_old = 1'b0; old_w = '0; old_age = '0;
		hit = 1'b0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			used[w]  = (w < int'(cmd_q.ways));
			match[w] = used[w] && vld_rd[w] &&
				(tags_rd[w*TAG_W +: TAG_W] == cmd_q.tag);
			older[w] = used[w] && vld_rd[w] && !match[w];
			aged[w]  = ages_rd[w*AGE_WIDTH +: AGE_WIDTH];
			if (match[w]) aged[w] = '0;
			else if (older[w] && aged[w] != AGE_MAX) aged[w] = aged[w] + AGE_WIDTH'(1);
			hit = hit | match[w];
		end
		// ordered scans for first free way and first oldest way
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (used[w] && !vld_rd[w] && !have_free) begin
				have_free = 1'b1; free_w = WAY_W'(w);
			end
			if (older[w] && (!have_old || aged[w] > old_age)) begin
				have_old = 1'b1; old_age = aged[w]; old_w = WAY_W'(w);
			end
		end
		evict = !hit && !have_free;
		tgt   = have_free ? free_w : old_w;
		tags_wr = tags_rd;
		ages_wr = '0;
		vld_wr  = vld_rd;
		for (int w = 0; w < MAX_WAYS; w++) begin
			ages_wr[w*AGE_WIDTH +: AGE_WIDTH] = aged[w];
		end
		if (!hit) begin
			tags_wr[tgt*TAG_W +: TAG_W]         = cmd_q.tag;
			ages_wr[tgt*AGE_WIDTH +: AGE_WIDTH] = '0;
			vld_wr[tgt]                         = 1'b1;
		end
		hits_d = cmd_q.modify ? sat_inc(hits_q) : hits_q;
		if (hit) hits_d = sat_inc(hits_d);
		miss_d = hit ? miss_q : sat_inc(miss_q);
		evc_d  = evict ? sat_inc(evc_q) : evc_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			res_q.access_hit       <= hit;
			res_q.line_evicted     <= evict;
			res_q.modify_extra_hit <= cmd_q.modify;
			res_q.total_hits       <= hits_d;
			res_q.total_misses     <= miss_d;
			res_q.total_evictions  <= evc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hits_q <= '0; miss_q <= '0; evc_q <= '0;
			clr_q <= '0;
		end else begin
			state_q <= state_d;
			if (!clr_done) clr_q <= clr_q + (MAX_SET_BITS+1)'(1);
			if (we) begin
				hits_q <= hits_d; miss_q <= miss_d; evc_q <= evc_d;
			end
		end
	end
endmodule

>>> design/set_assoc_lru_cache_tracker.sv
// An accepted access goes through queue pop, set read and update to result valid.
// One access at a time: set row rewritten and result taken before the next pops.
// Instruction fetches are accepted without entering the queue and give no result.
// Reset: async active low; counters zero, registers set to 1; a pass over all 64 sets
// then clears every line's valid bit before the first access is processed.
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tracker
// Tag-only set-associative cache with saturating age counters.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tracker import salru_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	salru_req_if.sink   req,
	salru_rsp_if.source rsp,
	salru_cfg_if.sink   cfg
);
	logic [2:0] set_bits_q;
	logic [3:0] ways_q;
	logic [5:0] blk_bits_q;
	logic push, q_full, q_empty, q_pop;
	cmd_t push_cmd, q_head;
	res_t res;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd1; ways_q <= 4'd1; blk_bits_q <= 6'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SET_BITS:   set_bits_q <= cfg.data[2:0];
				CFG_WAYS:       ways_q     <= cfg.data[3:0];
				CFG_BLOCK_BITS: blk_bits_q <= cfg.data;
				default: ;
			endcase
		end
	end

	salru_front u_front (
		.in_valid(req.valid), .in_ready(req.ready),
		.req_type(req.req_type), .address(req.address),
		.set_bits_q, .ways_q, .blk_bits_q, .push, .push_cmd, .q_full
	);

	salru_queue u_queue (
		.clk, .arst_n, .push, .push_cmd, .full(q_full),
		.pop(q_pop), .empty(q_empty), .head(q_head)
	);

	salru_back u_back (
		.clk, .arst_n, .q_empty, .q_head, .q_pop,
		.out_valid(rsp.valid), .out_ready(rsp.ready), .res
	);

	assign rsp.access_hit       = res.access_hit;
	assign rsp.line_evicted     = res.line_evicted;
	assign rsp.modify_extra_hit = res.modify_extra_hit;
	assign rsp.total_hits       = res.total_hits;
	assign rsp.total_misses     = res.total_misses;
	assign rsp.total_evictions  = res.total_evictions;

`ifndef SYNTHESIS
	a_no_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.access_hit && rsp.line_evicted)) else $error("hit and evict");
	a_queue_guard: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push) else $error("queue overflow");
	a_hits_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready) |=> ##1 (rsp.total_hits >= $past(rsp.total_hits,2)))
		else $error("hit count fell");
`endif
endmodule
